/* rtl/core/sha1_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants, including the round constants, for the SHA-1 hash block.
package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [4:0] hash_t;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 80;

  localparam word_t K0 = 32'h5A82_7999;
  localparam word_t K1 = 32'h6ED9_EBA1;
  localparam word_t K2 = 32'h8F1B_BCDC;
  localparam word_t K3 = 32'hCA62_C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  localparam hash_t InitHash = {32'hC3D2_E1F0, 32'h1032_5476, 32'h98BA_DCFE,
                                32'hEFCD_AB89, 32'h6745_2301};

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_DIGEST
  } state_e;

  // Next word that the padding sequence puts into the block.
  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN_LO,
    PAD_DONE
  } pad_e;

  // Control of the message schedule shift line.
  typedef struct packed {
    logic shift;
    logic use_round;
    logic early;
  } sched_ctl_t;

endpackage

/* rtl/core/sha1_hash.sv */
`timescale 1ns / 1ps
// Top level of the SHA-1 hash block: sequencer, chaining hash and digest output.
//
// Message words enter on the input channel, first byte in bits 31 to 24.
// valid_bytes below four is honored only on the word marked last_word.
// A word that does not complete a block is taken without a stall. The word
// that fills a block loads the working variables, runs 80 rounds on the
// one shared round unit (one round per cycle) and then folds the working
// variables into the chaining hash. No new word is taken during this round
// loop, which limits the sustained rate of message words.
// On the last word the block adds the marker byte, zero words and the 64-bit bit
// length one word per cycle outside rounds, hashing one or two final blocks,
// then presents the five digest words, most significant first, one beat each.
// in_stall_o stays high from the acceptance of a block-filling or last word
// until that work, including the digest, is done.
// While out_stall_i is high the current digest beat holds unchanged.
// After the fifth beat the hash returns to its initial values for a new
// message. Reset puts the block in the same fresh state, ready at once.
module sha1_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] message_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  digest_index_o,
  output logic        digest_last_o
);

  sha1_pkg::state_e     state_q, state_d;
  sha1_pkg::pad_e       pad_q, pad_d;
  logic                 fin_q, fin_d;
  logic [3:0]           pos_q;
  logic [6:0]           round_q, round_d;
  logic [2:0]           idx_q, idx_d;
  logic [63:0]          bitlen_q, bitlen_d;
  sha1_pkg::hash_t      chain_q, work_q, work_next;
  sha1_pkg::word_t      w_t;
  sha1_pkg::sched_ctl_t sched_ctl;
  logic                 put_en;
  sha1_pkg::word_t      put_data;
  logic                 rounding, fold, clear;
  logic [2:0]           nbytes;
  sha1_pkg::word_t      last_fmt;

  // Bytes taken from the word, and the last word with its marker byte.
  always_comb begin
    nbytes = (!last_word_i || valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
    unique case (nbytes)
      3'd0:    last_fmt = {sha1_pkg::PadByte, 24'h0};
      3'd1:    last_fmt = {message_word_i[31:24], sha1_pkg::PadByte, 16'h0};
      3'd2:    last_fmt = {message_word_i[31:16], sha1_pkg::PadByte, 8'h0};
      3'd3:    last_fmt = {message_word_i[31:8], sha1_pkg::PadByte};
      default: last_fmt = message_word_i;
    endcase
  end

  // Sequencer: next state and datapath controls.
  always_comb begin
    state_d  = state_q;
    pad_d    = pad_q;
    fin_d    = fin_q;
    round_d  = round_q;
    idx_d    = idx_q;
    bitlen_d = bitlen_q;
    put_en   = 1'b0;
    put_data = '0;
    rounding = 1'b0;
    fold     = 1'b0;
    clear    = 1'b0;
    unique case (state_q)
      sha1_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          put_en = 1'b1;
          if (!last_word_i) begin
            put_data = message_word_i;
            bitlen_d = bitlen_q + 64'd32;
            state_d  = (pos_q == 4'd15) ? sha1_pkg::ST_ROUND : sha1_pkg::ST_IDLE;
          end else begin
            put_data = last_fmt;
            bitlen_d = bitlen_q + {58'd0, nbytes, 3'd0};
            fin_d    = 1'b1;
            pad_d    = (nbytes == 3'd4) ? sha1_pkg::PAD_MARK : sha1_pkg::PAD_ZERO;
            state_d  = (pos_q == 4'd15) ? sha1_pkg::ST_ROUND : sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        put_en = 1'b1;
        unique case (pad_q)
          sha1_pkg::PAD_MARK: begin
            put_data = {sha1_pkg::PadByte, 24'h0};
            pad_d    = sha1_pkg::PAD_ZERO;
          end
          sha1_pkg::PAD_ZERO: begin
            if (pos_q == 4'd14) begin
              put_data = bitlen_q[63:32];
              pad_d    = sha1_pkg::PAD_LEN_LO;
            end
          end
          sha1_pkg::PAD_LEN_LO: begin
            put_data = bitlen_q[31:0];
            pad_d    = sha1_pkg::PAD_DONE;
          end
          default: begin
            put_en = 1'b0;
          end
        endcase
        state_d = (put_en && pos_q == 4'd15) ? sha1_pkg::ST_ROUND : sha1_pkg::ST_PAD;
      end
      sha1_pkg::ST_ROUND: begin
        rounding = 1'b1;
        if (round_q == 7'(sha1_pkg::Rounds - 1)) begin
          round_d = '0;
          state_d = sha1_pkg::ST_FOLD;
        end else begin
          round_d = round_q + 7'd1;
        end
      end
      sha1_pkg::ST_FOLD: begin
        fold = 1'b1;
        if (!fin_q) begin
          state_d = sha1_pkg::ST_IDLE;
        end else if (pad_q == sha1_pkg::PAD_DONE) begin
          state_d = sha1_pkg::ST_DIGEST;
        end else begin
          state_d = sha1_pkg::ST_PAD;
        end
      end
      sha1_pkg::ST_DIGEST: begin
        if (!out_stall_i) begin
          if (idx_q == 3'd4) begin
            clear   = 1'b1;
            idx_d   = '0;
            state_d = sha1_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = sha1_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Counters, chaining hash and working variables.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q    <= sha1_pkg::PAD_ZERO;
      fin_q    <= 1'b0;
      pos_q    <= '0;
      round_q  <= '0;
      idx_q    <= '0;
      bitlen_q <= '0;
      chain_q  <= sha1_pkg::InitHash;
      work_q   <= '0;
    end else begin
      round_q <= round_d;
      idx_q   <= idx_d;
      if (put_en) begin
        pos_q <= pos_q + 4'd1;
      end
      if (clear) begin
        pad_q    <= sha1_pkg::PAD_ZERO;
        fin_q    <= 1'b0;
        bitlen_q <= '0;
        chain_q  <= sha1_pkg::InitHash;
      end else begin
        pad_q    <= pad_d;
        fin_q    <= fin_d;
        bitlen_q <= bitlen_d;
        if (fold) begin
          for (int i = 0; i < 5; i++) begin
            chain_q[i] <= chain_q[i] + work_q[i];
          end
        end
      end
      if (put_en && pos_q == 4'd15) begin
        work_q <= chain_q;
      end else if (rounding) begin
        work_q <= work_next;
      end
    end
  end

  // Schedule window and the shared round unit.
  assign sched_ctl.shift     = put_en | rounding;
  assign sched_ctl.use_round = rounding;
  assign sched_ctl.early     = round_q < 7'(sha1_pkg::BlockWords);

  sha1_sched u_sched (
    .clk_i       (clk_i),
    .ctl_i       (sched_ctl),
    .load_word_i (put_data),
    .w_o         (w_t)
  );

  sha1_round u_round (
    .work_i  (work_q),
    .w_i     (w_t),
    .round_i (round_q),
    .work_o  (work_next)
  );

  // Ports.
  assign in_stall_o     = (state_q != sha1_pkg::ST_IDLE);
  assign out_valid_o    = (state_q == sha1_pkg::ST_DIGEST);
  assign digest_word_o  = chain_q[idx_q];
  assign digest_index_o = idx_q;
  assign digest_last_o  = (idx_q == 3'd4);

endmodule

/* rtl/core/sha1_sched.sv */
`timescale 1ns / 1ps
// Message schedule window of SHA-1 as a sixteen-word shift line.
module sha1_sched (
  input  logic                 clk_i,
  input  sha1_pkg::sched_ctl_t ctl_i,
  input  sha1_pkg::word_t      load_word_i,
  output sha1_pkg::word_t      w_o
);

  logic [15:0][31:0] win_q, win_d;
  sha1_pkg::word_t   mix;
  sha1_pkg::word_t   w_round;
  sha1_pkg::word_t   shift_in;

  // The oldest word sits at tap 0; taps 13, 8 and 2 are t-3, t-8 and t-14.
  always_comb begin
    mix     = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
    w_round = ctl_i.early ? win_q[0] : {mix[30:0], mix[31]};
    shift_in = ctl_i.use_round ? w_round : load_word_i;
    win_d   = ctl_i.shift ? {shift_in, win_q[15:1]} : win_q;
  end

  assign w_o = w_round;

  // The window holds data only; it is written before it is read.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

/* rtl/core/sha1_round.sv */
`timescale 1ns / 1ps
// One SHA-1 compression round, shared by all eighty rounds of a block.
module sha1_round (
  input  sha1_pkg::hash_t  work_i,
  input  sha1_pkg::word_t  w_i,
  input  logic [6:0]       round_i,
  output sha1_pkg::hash_t  work_o
);

  sha1_pkg::word_t a, b, c, d, e;
  sha1_pkg::word_t f, k, tmp;

  // Round function and constant follow the round group.
  always_comb begin
    a = work_i[0];
    b = work_i[1];
    c = work_i[2];
    d = work_i[3];
    e = work_i[4];
    priority if (round_i < 7'd20) begin
      f = (b & c) | (~b & d);
      k = sha1_pkg::K0;
    end else if (round_i < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1_pkg::K1;
    end else if (round_i < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1_pkg::K3;
    end
    tmp = {a[26:0], a[31:27]} + f + e + w_i + k;
    work_o[0] = tmp;
    work_o[1] = a;
    work_o[2] = {b[1:0], b[31:2]};
    work_o[3] = c;
    work_o[4] = d;
  end

endmodule

/* rtl/core/sha1_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the SHA-1 hash block and their binding to the top level.
module sha1_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  digest_index_o,
  input logic        digest_last_o
);

  // No message word is taken while the digest is being delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted during digest output");

  // The last flag marks exactly the fifth digest word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digest_last_o == (digest_index_o == 3'd4)))
    else $error("digest_last does not match digest_index");

  // A taken beat that is not the last is followed by the next index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !digest_last_o) |=>
      (out_valid_o && digest_index_o == $past(digest_index_o) + 3'd1))
    else $error("digest words out of sequence");

  // After the final beat the block is ready for a new message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && digest_last_o) |=> (!out_valid_o && !in_stall_o))
    else $error("block not ready after digest");

  // A stalled digest beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(digest_word_o)))
    else $error("stalled digest beat changed");

endmodule

bind sha1_hash sha1_checker u_sha1_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .digest_word_o  (digest_word_o),
  .digest_index_o (digest_index_o),
  .digest_last_o  (digest_last_o)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the SHA-1 hash block, with its own digest predictor.
module tb_top;

  localparam int unsigned RandomWords = 310;
  localparam int unsigned CalmAfter   = 270;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned DrainCycles = 40;

  // One row of input stimulus, with a digest typed in where it is well known.
  typedef struct {
    sha1_pkg::word_t word;
    logic [2:0]      nbytes;
    logic            last;
    logic            has_digest;
    sha1_pkg::hash_t digest;
  } msg_row_t;

  // One expected digest beat.
  typedef struct {
    sha1_pkg::word_t word;
    logic [2:0]      index;
    logic            last;
  } digest_beat_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  sha1_pkg::word_t message_word = '0;
  logic [2:0]      valid_bytes = '0;
  logic            last_word = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  sha1_pkg::word_t digest_word;
  logic [2:0]      digest_index;
  logic            digest_last;

  // Predictor state: chaining hash, partial block and running message length.
  sha1_pkg::word_t chain [5];
  sha1_pkg::word_t block_buf [16];
  int unsigned     block_pos;
  logic [63:0]     bit_count;

  digest_beat_t    digest_q [$];
  msg_row_t        dir_rows [$];
  logic            row_has_digest = 1'b0;
  sha1_pkg::hash_t row_digest = '0;
  logic            calm = 1'b0;
  logic            held_off = 1'b0;
  int unsigned     words_sent = 0;
  int unsigned     messages_done = 0;
  int unsigned     digests_seen = 0;
  int unsigned     fail_count = 0;

  sha1_hash dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .message_word_i (message_word),
    .valid_bytes_i  (valid_bytes),
    .last_word_i    (last_word),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .digest_word_o  (digest_word),
    .digest_index_o (digest_index),
    .digest_last_o  (digest_last)
  );

  // Free-running 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic sha1_pkg::word_t rotl(sha1_pkg::word_t x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Back to the fresh state that starts a new message.
  function automatic void sha_restart();
    for (int i = 0; i < 5; i++) chain[i] = sha1_pkg::InitHash[i];
    for (int i = 0; i < 16; i++) block_buf[i] = '0;
    block_pos = 0;
    bit_count = '0;
  endfunction

  // Eighty rounds over the buffered block, folded into the chaining hash.
  function automatic void sha_compress();
    sha1_pkg::word_t sched [80];
    sha1_pkg::word_t a, b, c, d, e, f, k, t;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) sched[r] = block_buf[r];
      else sched[r] = rotl(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1_pkg::K3;
      end
      t = rotl(a, 5) + f + e + sched[r] + k;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  function automatic void sha_absorb_word(sha1_pkg::word_t w);
    block_buf[block_pos] = w;
    block_pos = (block_pos + 1) % 16;
    if (block_pos == 0) sha_compress();
  endfunction

  // Takes one accepted beat; on the last word it pads, compresses and queues the digest.
  function automatic void sha_take_beat(sha1_pkg::word_t w, logic [2:0] nb_in, logic lw,
                                        logic use_known, sha1_pkg::hash_t known);
    int unsigned     nb;
    sha1_pkg::word_t mask;
    nb = (!lw || nb_in > 4) ? 4 : nb_in;
    bit_count += 64'(nb * 8);
    if (!lw) begin
      sha_absorb_word(w);
      return;
    end
    if (nb == 4) begin
      sha_absorb_word(w);
      sha_absorb_word({sha1_pkg::PadByte, 24'h0});
    end else begin
      mask = ~(32'hFFFF_FFFF >> (8 * nb));
      sha_absorb_word((w & mask) | ({sha1_pkg::PadByte, 24'h0} >> (8 * nb)));
    end
    if (block_pos == 15) sha_absorb_word('0);
    while (block_pos != 14) sha_absorb_word('0);
    sha_absorb_word(bit_count[63:32]);
    sha_absorb_word(bit_count[31:0]);
    for (int i = 0; i < 5; i++) begin
      digest_q.push_back('{use_known ? known[i] : chain[i], 3'(i), i == 4});
    end
    messages_done++;
    sha_restart();
  endfunction

  function automatic msg_row_t row(sha1_pkg::word_t w, logic [2:0] nb, logic lw,
                                   logic has_d = 1'b0, sha1_pkg::hash_t d = '0);
    msg_row_t r;
    r.word = w;
    r.nbytes = nb;
    r.last = lw;
    r.has_digest = has_d;
    r.digest = d;
    return r;
  endfunction

  // Monitor: predict on each input beat, then check each digest beat.
  always @(posedge clk_i) begin
    digest_beat_t exp_beat;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        sha_take_beat(message_word, valid_bytes, last_word, row_has_digest, row_digest);
      end
      if (out_valid && !out_stall) begin
        digests_seen++;
        if (digest_q.size() == 0) begin
          $error("digest beat with no message pending: word %h index %0d",
                 digest_word, digest_index);
          fail_count++;
        end else begin
          exp_beat = digest_q.pop_front();
          if (digest_word !== exp_beat.word) begin
            $error("digest_word: expected %h, got %h", exp_beat.word, digest_word);
            fail_count++;
          end
          if (digest_index !== exp_beat.index) begin
            $error("digest_index: expected %0d, got %0d", exp_beat.index, digest_index);
            fail_count++;
          end
          if (digest_last !== exp_beat.last) begin
            $error("digest_last: expected %0b, got %0b", exp_beat.last, digest_last);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // Receiver: short random stalls, plus one long hold-off that backs up the input.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && digests_seen >= 10) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one beat at a falling edge and returns at the falling edge after acceptance.
  task automatic drive_word(input msg_row_t r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    message_word <= r.word;
    valid_bytes <= r.nbytes;
    last_word <= r.last;
    row_has_digest = r.has_digest;
    row_digest = r.digest;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    words_sent++;
    if (words_sent >= CalmAfter) calm = 1'b1;
    @(negedge clk_i);
  endtask

  // Random word with a bias toward all zeros and all ones.
  function automatic sha1_pkg::word_t pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned n_body;
    msg_row_t    r;

    sha_restart();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed messages. Digest words are concatenated with index 0 in the low slot.
    // Empty message: the word content is ignored.
    dir_rows.push_back(row(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1,
      {32'hAFD8_0709, 32'h9560_1890, 32'h3255_BFEF, 32'h5E6B_4B0D, 32'hDA39_A3EE}));
    // The three bytes "abc".
    dir_rows.push_back(row(32'h6162_6300, 3'd3, 1'b1, 1'b1,
      {32'h9CD0_D89D, 32'h7850_C26C, 32'hBA3E_2571, 32'h4706_816A, 32'hA999_3E36}));
    // Byte counts above four on a last word act as four.
    dir_rows.push_back(row(32'hFFFF_FFFF, 3'd7, 1'b1));
    dir_rows.push_back(row(32'h0000_0000, 3'd4, 1'b1));
    // A short count on a word that is not last is ignored.
    dir_rows.push_back(row(32'hFFFF_FFFF, 3'd1, 1'b0));
    dir_rows.push_back(row(32'h8000_0001, 3'd2, 1'b1));
    dir_rows.push_back(row(32'h1234_5678, 3'd5, 1'b1));
    // Fifteen words and then a full last word: the marker byte opens a new block.
    for (int i = 0; i < 15; i++) begin
      dir_rows.push_back(row(i[0] ? 32'h0000_0000 : 32'hFFFF_FFFF, 3'(i), 1'b0));
    end
    dir_rows.push_back(row(32'hA5A5_A5A5, 3'd4, 1'b1));
    dir_rows.push_back(row(32'hFFFF_FFFF, 3'd6, 1'b1));
    foreach (dir_rows[i]) drive_word(dir_rows[i]);

    // Random messages, lengths weighted toward the block boundaries.
    while (words_sent < RandomWords) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: n_body = $urandom_range(0, 6);
        5, 6, 7:       n_body = $urandom_range(12, 17);
        8:             n_body = $urandom_range(28, 33);
        default:       n_body = $urandom_range(0, 40);
      endcase
      for (int i = 0; i < n_body; i++) begin
        r = row(pick_word(), ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                1'b0);
        drive_word(r);
      end
      drive_word(row(pick_word(), 3'($urandom_range(0, 7)), 1'b1));
    end
    in_valid <= 1'b0;

    // Drain outstanding digests, then watch a little longer for stray beats.
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Hashed %0d messages from %0d input words, %0d digest beats checked.",
             messages_done, words_sent, digests_seen);
    $display("%s", {"Covered empty, short, full and oversized last words ",
                    "and one- and two-block padding."});
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/sha1_pkg.sv
rtl/core/sha1_sched.sv
rtl/core/sha1_round.sv
rtl/core/sha1_hash.sv
rtl/core/sha1_checker.sv
verif/tb_top.sv
